// File: src/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg
// Types, codes and constants shared by the stepper run supervisor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package srs_pkg;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_MOVE  = 2'd1,
		CMD_STOP  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_RUN   = 2'd1,
		MODE_FAULT = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		LOAD_NORMAL  = 2'd0,
		LOAD_REDUCED = 2'd1,
		LOAD_STOPPED = 2'd2
	} load_t;

	typedef enum logic [2:0] {
		REASON_NONE     = 3'd0,
		REASON_NORMAL   = 3'd1,
		REASON_TIMEOUT  = 3'd2,
		REASON_OVERLOAD = 3'd3,
		REASON_DRVFAULT = 3'd4
	} reason_t;

	typedef enum logic [2:0] {
		REG_COMMAND_SPEED    = 3'd0,
		REG_TORQUE_THRESHOLD = 3'd1,
		REG_REDUCED_SPEED    = 3'd2,
		REG_LOW_TO_REDUCE    = 3'd3,
		REG_LOW_TO_STOP      = 3'd4,
		REG_UP_LEG_LIMIT     = 3'd5,
		REG_DOWN_LEG_LIMIT   = 3'd6,
		REG_RUN_LIMIT_TICKS  = 3'd7
	} reg_idx_t;

	localparam int CFG_DATA_W = 24;

	localparam logic [12:0] SPEED_MAX        = 13'd8000;
	localparam logic [3:0]  SAMPLE_TICKS     = 4'd10;
	localparam logic [4:0]  COUNT_MAX        = 5'd31;
	localparam logic [15:0] TICKS_MAX        = 16'hFFFF;

	localparam logic [12:0] RST_COMMAND_SPEED = 13'd500;
	localparam logic [11:0] RST_TORQUE_THRESH = 12'd400;
	localparam logic [12:0] RST_REDUCED_SPEED = 13'd800;
	localparam logic [4:0]  RST_LOW_TO_REDUCE = 5'd6;
	localparam logic [4:0]  RST_LOW_TO_STOP   = 5'd24;
	localparam logic [23:0] RST_UP_LEG_LIMIT  = 24'd4697;
	localparam logic [23:0] RST_DOWN_LEG_LIMIT = 24'd4972;
	localparam logic [15:0] RST_RUN_LIMIT     = 16'd6000;

	typedef struct packed {
		logic [1:0]  cmd;
		logic        move_dir;
		logic [23:0] move_steps;
		logic        timer_running;
		logic [23:0] steps_done;
		logic        driver_fault_bit;
		logic        driver_stall_bit;
		logic        fault_pin_low;
		logic [11:0] torque_count;
	} srs_in_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic        accepted;
		logic        driver_enable;
		logic        timer_start;
		logic        timer_stop;
		logic [23:0] step_target;
		logic [12:0] speed_now;
		logic [1:0]  load_state;
		logic [2:0]  stop_reason;
		logic [1:0]  switch_errors;
		logic        clear_driver_fault;
	} srs_out_t;

	typedef struct packed {
		logic [12:0] command_speed;
		logic [11:0] torque_threshold;
		logic [12:0] reduced_speed;
		logic [4:0]  low_to_reduce;
		logic [4:0]  low_to_stop;
		logic [23:0] up_leg_limit;
		logic [23:0] down_leg_limit;
		logic [15:0] run_limit_ticks;
	} srs_cfg_t;

	typedef struct packed {
		logic        speed_wr;
		logic [12:0] speed;
		logic        clear_low;
	} srs_cfg_evt_t;

	typedef struct packed {
		mode_t       run_mode;
		logic        leg_dir;
		logic        fault_latch;
		logic        stall_latch;
		load_t       load_mode;
		logic [4:0]  low_run;
		logic [4:0]  reduced_low_run;
		logic [15:0] ticks_in_move;
		logic [3:0]  sample_divider;
		logic [12:0] active_speed;
		logic [1:0]  switch_error_bits;
		reason_t     last_reason;
	} srs_state_t;

	function automatic logic [12:0] clamp_speed(input logic [12:0] v);
		logic [12:0] r;
		r = v;
		if (v == 13'd0) begin
			r = 13'd1;
		end else if (v > SPEED_MAX) begin
			r = SPEED_MAX;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: src/srs_cfg_regs.sv
// ----------------------------------------------------------------------------
// srs_cfg_regs
// Configuration register file with write-time clamping and side-effect events.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [2:0]                      wr_index,
	input  wire logic [srs_pkg::CFG_DATA_W-1:0]  wr_data,
	output srs_pkg::srs_cfg_t                    cfg,
	output srs_pkg::srs_cfg_evt_t                evt
);
	import srs_pkg::*;

	srs_cfg_t    cfg_q;
	logic [11:0] thresh_wr;

	assign thresh_wr = (wr_data[11:0] == 12'd0) ? 12'd1 : wr_data[11:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.command_speed    <= RST_COMMAND_SPEED;
			cfg_q.torque_threshold <= RST_TORQUE_THRESH;
			cfg_q.reduced_speed    <= RST_REDUCED_SPEED;
			cfg_q.low_to_reduce    <= RST_LOW_TO_REDUCE;
			cfg_q.low_to_stop      <= RST_LOW_TO_STOP;
			cfg_q.up_leg_limit     <= RST_UP_LEG_LIMIT;
			cfg_q.down_leg_limit   <= RST_DOWN_LEG_LIMIT;
			cfg_q.run_limit_ticks  <= RST_RUN_LIMIT;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_COMMAND_SPEED:    cfg_q.command_speed <= clamp_speed(wr_data[12:0]);
				REG_TORQUE_THRESHOLD: cfg_q.torque_threshold <= thresh_wr;
				REG_REDUCED_SPEED:    cfg_q.reduced_speed <= clamp_speed(wr_data[12:0]);
				REG_LOW_TO_REDUCE:    cfg_q.low_to_reduce <= wr_data[4:0];
				REG_LOW_TO_STOP:      cfg_q.low_to_stop <= wr_data[4:0];
				REG_UP_LEG_LIMIT:     cfg_q.up_leg_limit <= wr_data[23:0];
				REG_DOWN_LEG_LIMIT:   cfg_q.down_leg_limit <= wr_data[23:0];
				REG_RUN_LIMIT_TICKS:  cfg_q.run_limit_ticks <= wr_data[15:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

	always_comb begin
		evt.speed_wr  = wr_en && (reg_idx_t'(wr_index) == REG_COMMAND_SPEED);
		evt.speed     = clamp_speed(wr_data[12:0]);
		evt.clear_low = wr_en && (reg_idx_t'(wr_index) == REG_TORQUE_THRESHOLD);
	end

endmodule

`default_nettype wire

// File: src/srs_step_core.sv
// ----------------------------------------------------------------------------
// srs_step_core
// Supervisor state register and the single-pass next-state and result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_step_core (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   step_en,
	input  wire srs_pkg::srs_in_t       item,
	input  wire srs_pkg::srs_cfg_t      cfg,
	input  wire srs_pkg::srs_cfg_evt_t  evt,
	output srs_pkg::srs_out_t           res
);
	import srs_pkg::*;

	srs_state_t  st_q;
	srs_state_t  nx;
	logic [15:0] ticks_inc;
	logic [3:0]  div_inc;
	logic [4:0]  low_inc;
	logic [4:0]  rlow_inc;
	logic        torque_low;
	logic        up_hit;
	logic        down_hit;
	logic        fault_hit;
	logic        timeout_hit;
	logic        accepted;
	logic        tstart;
	logic        tstop;
	logic        clr;
	logic [23:0] target;

	always_comb begin
		ticks_inc   = (st_q.ticks_in_move == TICKS_MAX) ? TICKS_MAX : st_q.ticks_in_move + 16'd1;
		div_inc     = st_q.sample_divider + 4'd1;
		low_inc     = (st_q.low_run == COUNT_MAX) ? COUNT_MAX : st_q.low_run + 5'd1;
		rlow_inc    = (st_q.reduced_low_run == COUNT_MAX) ? COUNT_MAX :
		              st_q.reduced_low_run + 5'd1;
		torque_low  = item.torque_count < cfg.torque_threshold;
		up_hit      = !st_q.leg_dir && (item.steps_done >= cfg.up_leg_limit);
		down_hit    = st_q.leg_dir && (item.steps_done >= cfg.down_leg_limit);
		fault_hit   = item.driver_fault_bit || item.driver_stall_bit || item.fault_pin_low;
		timeout_hit = ticks_inc >= cfg.run_limit_ticks;
	end

	always_comb begin
		nx       = st_q;
		accepted = 1'b0;
		tstart   = 1'b0;
		tstop    = 1'b0;
		clr      = 1'b0;
		target   = '0;
		unique case (cmd_t'(item.cmd))
			CMD_MOVE: begin
				if (st_q.run_mode != MODE_FAULT) begin
					accepted           = 1'b1;
					tstart             = 1'b1;
					tstop              = 1'b1;
					target             = item.move_steps;
					clr                = st_q.fault_latch;
					nx.leg_dir         = item.move_dir;
					nx.fault_latch     = 1'b0;
					nx.load_mode       = LOAD_NORMAL;
					nx.low_run         = '0;
					nx.reduced_low_run = '0;
					nx.active_speed    = cfg.command_speed;
					nx.ticks_in_move   = '0;
					nx.sample_divider  = '0;
					nx.run_mode        = MODE_RUN;
				end
			end
			CMD_STOP: begin
				tstop          = 1'b1;
				nx.run_mode    = MODE_IDLE;
				nx.load_mode   = LOAD_NORMAL;
				nx.last_reason = REASON_NORMAL;
			end
			CMD_CLEAR: begin
				clr                  = 1'b1;
				nx.fault_latch       = 1'b0;
				nx.stall_latch       = 1'b0;
				nx.switch_error_bits = '0;
				if (st_q.run_mode == MODE_FAULT) begin
					nx.run_mode = MODE_IDLE;
				end
			end
			CMD_TICK: begin
				if (st_q.run_mode != MODE_FAULT) begin
					nx.fault_latch = item.driver_fault_bit;
					nx.stall_latch = item.driver_stall_bit;
				end
				if (st_q.run_mode == MODE_RUN) begin
					nx.ticks_in_move = ticks_inc;
					if (!item.timer_running) begin
						nx.run_mode    = MODE_IDLE;
						nx.last_reason = REASON_NORMAL;
					end else if (up_hit || down_hit) begin
						tstop                = 1'b1;
						nx.run_mode          = MODE_IDLE;
						nx.load_mode         = LOAD_NORMAL;
						nx.switch_error_bits = st_q.switch_error_bits | {down_hit, up_hit};
						nx.last_reason       = REASON_OVERLOAD;
					end else if (fault_hit) begin
						tstop          = 1'b1;
						nx.run_mode    = MODE_FAULT;
						nx.last_reason = REASON_DRVFAULT;
					end else if (timeout_hit) begin
						tstop          = 1'b1;
						nx.run_mode    = MODE_IDLE;
						nx.load_mode   = LOAD_NORMAL;
						nx.last_reason = REASON_TIMEOUT;
					end else if (div_inc >= SAMPLE_TICKS) begin
						nx.sample_divider = '0;
						if (torque_low) begin
							if (st_q.load_mode == LOAD_REDUCED) begin
								nx.reduced_low_run = rlow_inc;
								if (rlow_inc >= cfg.low_to_stop) begin
									tstop          = 1'b1;
									nx.run_mode    = MODE_IDLE;
									nx.load_mode   = LOAD_STOPPED;
									nx.last_reason = REASON_OVERLOAD;
								end
							end else begin
								nx.low_run = low_inc;
								if (low_inc >= cfg.low_to_reduce) begin
									nx.reduced_low_run = '0;
									nx.load_mode       = LOAD_REDUCED;
									nx.active_speed    = cfg.reduced_speed;
								end
							end
						end else begin
							nx.low_run         = '0;
							nx.reduced_low_run = '0;
							if (st_q.load_mode == LOAD_REDUCED) begin
								nx.active_speed = cfg.command_speed;
							end
							nx.load_mode = LOAD_NORMAL;
						end
					end else begin
						nx.sample_divider = div_inc;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res.mode               = nx.run_mode;
		res.accepted           = accepted;
		res.driver_enable      = (nx.run_mode == MODE_RUN);
		res.timer_start        = tstart;
		res.timer_stop         = tstop;
		res.step_target        = target;
		res.speed_now          = nx.active_speed;
		res.load_state         = nx.load_mode;
		res.stop_reason        = nx.last_reason;
		res.switch_errors      = nx.switch_error_bits;
		res.clear_driver_fault = clr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.run_mode          <= MODE_IDLE;
			st_q.leg_dir           <= 1'b0;
			st_q.fault_latch       <= 1'b0;
			st_q.stall_latch       <= 1'b0;
			st_q.load_mode         <= LOAD_NORMAL;
			st_q.low_run           <= '0;
			st_q.reduced_low_run   <= '0;
			st_q.ticks_in_move     <= '0;
			st_q.sample_divider    <= '0;
			st_q.active_speed      <= RST_COMMAND_SPEED;
			st_q.switch_error_bits <= '0;
			st_q.last_reason       <= REASON_NONE;
		end else if (step_en) begin
			st_q <= nx;
		end else begin
			if (evt.speed_wr) begin
				st_q.active_speed <= evt.speed;
			end
			if (evt.clear_low) begin
				st_q.low_run         <= '0;
				st_q.reduced_low_run <= '0;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/stepper_run_supervisor_unit.sv
// ----------------------------------------------------------------------------
// stepper_run_supervisor_unit
// An accepted transaction sits in the input register until its result is registered.
// Throughput: one per cycle without stalls; the result register frees as it is taken.
// The supervisor state updates in a single pass between input and result registers.
// Reset: asynchronous, active low; idle mode, default registers, no pending results.
// Configuration writes are taken every cycle and apply on the following edge.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_run_supervisor_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire srs_pkg::srs_in_t                in_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output srs_pkg::srs_out_t                    out_data,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [2:0]                      cfg_index,
	input  wire logic [srs_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import srs_pkg::*;

	logic         valid_s1;
	srs_in_t      item_s1;
	logic         out_valid_q;
	srs_out_t     out_data_q;
	logic         advance;
	srs_cfg_t     cfg;
	srs_cfg_evt_t evt;
	srs_out_t     res;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	srs_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg),
		.evt      (evt)
	);

	srs_step_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.evt     (evt),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// File: src/srs_port_checker.sv
// ----------------------------------------------------------------------------
// srs_port_checker
// Port-level checks on the stepper run supervisor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_port_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire srs_pkg::srs_out_t out_data
);
	import srs_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("Result transaction changed while stalled.");

	a_enable_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.driver_enable == (out_data.mode == MODE_RUN)))
		else $error("Driver enable disagrees with mode.");

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.accepted |->
			out_data.timer_start && out_data.timer_stop && (out_data.mode == MODE_RUN))
		else $error("Accepted move did not restart the timer in run mode.");

	a_start_only_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.timer_start || (out_data.step_target != '0)) |->
			out_data.accepted)
		else $error("Timer start or target without an accepted move.");

endmodule

bind stepper_run_supervisor_unit srs_port_checker u_port_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

// File: verif/srs_checker.sv
// ----------------------------------------------------------------------------
// srs_checker
// Watches the command, result and register channels of the stepper run
// supervisor. It keeps its own model of the supervisor state and registers,
// works out the result of every accepted command and compares each result
// that the block hands over, field by field, in order.
// ----------------------------------------------------------------------------
module srs_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire logic                           in_ready,
	input  srs_pkg::srs_in_t                    in_data,
	input  wire logic                           out_valid,
	input  wire logic                           out_ready,
	input  srs_pkg::srs_out_t                   out_data,
	input  wire logic                           cfg_valid,
	input  wire logic                           cfg_ready,
	input  wire logic [2:0]                     cfg_index,
	input  wire logic [srs_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                                  failures,
	output int                                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import srs_pkg::*;

	logic [12:0] cmd_speed;
	logic [11:0] trq_thresh;
	logic [12:0] red_speed;
	logic [4:0]  n_reduce;
	logic [4:0]  n_stop;
	logic [23:0] up_lim;
	logic [23:0] dn_lim;
	logic [15:0] tick_lim;

	mode_t       mode_q;
	logic        dir_q;
	logic        flt_q;
	logic        stl_q;
	load_t       load_q;
	logic [4:0]  low_cnt;
	logic [4:0]  red_low_cnt;
	logic [15:0] move_ticks;
	logic [3:0]  smp_div;
	logic [12:0] speed_q;
	logic [1:0]  sw_err;
	reason_t     reason_q;

	srs_out_t    expected_q[$];

	function automatic logic [12:0] fit_speed(input logic [12:0] v);
		if (v == 13'd0) begin
			return 13'd1;
		end
		return (v > SPEED_MAX) ? SPEED_MAX : v;
	endfunction

	function automatic logic [4:0] bump_count(input logic [4:0] v);
		return (v >= COUNT_MAX) ? COUNT_MAX : v + 5'd1;
	endfunction

	task automatic report_failure(input string msg);
		if (failures < 40) begin
			$display("ERROR at %0t ns: %s", $time, msg);
		end
		failures = failures + 1;
	endtask

	task automatic check_field(input string name, input logic [23:0] got,
			input logic [23:0] want);
		if (got !== want) begin
			report_failure($sformatf("%s: got %0d, expected %0d", name, got, want));
		end
	endtask

	task automatic reset_model();
		cmd_speed   = RST_COMMAND_SPEED;
		trq_thresh  = RST_TORQUE_THRESH;
		red_speed   = RST_REDUCED_SPEED;
		n_reduce    = RST_LOW_TO_REDUCE;
		n_stop      = RST_LOW_TO_STOP;
		up_lim      = RST_UP_LEG_LIMIT;
		dn_lim      = RST_DOWN_LEG_LIMIT;
		tick_lim    = RST_RUN_LIMIT;
		mode_q      = MODE_IDLE;
		dir_q       = 1'b0;
		flt_q       = 1'b0;
		stl_q       = 1'b0;
		load_q      = LOAD_NORMAL;
		low_cnt     = '0;
		red_low_cnt = '0;
		move_ticks  = '0;
		smp_div     = '0;
		speed_q     = RST_COMMAND_SPEED;
		sw_err      = '0;
		reason_q    = REASON_NONE;
	endtask

	task automatic apply_register(input logic [2:0] idx, input logic [23:0] d);
		case (idx)
			REG_COMMAND_SPEED: begin
				cmd_speed = fit_speed(d[12:0]);
				speed_q   = cmd_speed;
			end
			REG_TORQUE_THRESHOLD: begin
				trq_thresh  = (d[11:0] == 12'd0) ? 12'd1 : d[11:0];
				low_cnt     = '0;
				red_low_cnt = '0;
			end
			REG_REDUCED_SPEED:   red_speed = fit_speed(d[12:0]);
			REG_LOW_TO_REDUCE:   n_reduce  = d[4:0];
			REG_LOW_TO_STOP:     n_stop    = d[4:0];
			REG_UP_LEG_LIMIT:    up_lim    = d;
			REG_DOWN_LEG_LIMIT:  dn_lim    = d;
			REG_RUN_LIMIT_TICKS: tick_lim  = d[15:0];
			default: ;
		endcase
	endtask

	// Tick handling in run: the first stop condition that holds ends the move,
	// and torque is only sampled on ticks that leave the move running.
	task automatic supervise_tick(input srs_in_t it, inout srs_out_t r);
		logic ended;
		ended = 1'b0;
		if (mode_q != MODE_FAULT) begin
			flt_q = it.driver_fault_bit;
			stl_q = it.driver_stall_bit;
		end
		if (mode_q == MODE_RUN) begin
			if (move_ticks != TICKS_MAX) begin
				move_ticks = move_ticks + 16'd1;
			end
			ended = 1'b1;
			if (!it.timer_running) begin
				mode_q   = MODE_IDLE;
				reason_q = REASON_NORMAL;
			end else if ((!dir_q && it.steps_done >= up_lim) ||
					(dir_q && it.steps_done >= dn_lim)) begin
				r.timer_stop = 1'b1;
				mode_q       = MODE_IDLE;
				load_q       = LOAD_NORMAL;
				sw_err       = sw_err | (dir_q ? 2'b10 : 2'b01);
				reason_q     = REASON_OVERLOAD;
			end else if (flt_q || stl_q || it.fault_pin_low) begin
				r.timer_stop = 1'b1;
				mode_q       = MODE_FAULT;
				reason_q     = REASON_DRVFAULT;
			end else if (move_ticks >= tick_lim) begin
				r.timer_stop = 1'b1;
				mode_q       = MODE_IDLE;
				load_q       = LOAD_NORMAL;
				reason_q     = REASON_TIMEOUT;
			end else begin
				ended = 1'b0;
			end
			if (!ended) begin
				smp_div = smp_div + 4'd1;
				if (smp_div >= SAMPLE_TICKS) begin
					smp_div = '0;
					if (it.torque_count < trq_thresh) begin
						if (load_q == LOAD_REDUCED) begin
							red_low_cnt = bump_count(red_low_cnt);
							if (red_low_cnt >= n_stop) begin
								r.timer_stop = 1'b1;
								mode_q       = MODE_IDLE;
								load_q       = LOAD_STOPPED;
								reason_q     = REASON_OVERLOAD;
							end
						end else begin
							low_cnt = bump_count(low_cnt);
							if (low_cnt >= n_reduce) begin
								red_low_cnt = '0;
								load_q      = LOAD_REDUCED;
								speed_q     = red_speed;
							end
						end
					end else begin
						low_cnt     = '0;
						red_low_cnt = '0;
						if (load_q == LOAD_REDUCED) begin
							speed_q = cmd_speed;
						end
						load_q = LOAD_NORMAL;
					end
				end
			end
		end
	endtask

	task automatic supervise(input srs_in_t it, output srs_out_t r);
		r = '0;
		case (it.cmd)
			CMD_MOVE: begin
				if (mode_q != MODE_FAULT) begin
					r.accepted    = 1'b1;
					r.timer_start = 1'b1;
					r.timer_stop  = 1'b1;
					r.step_target = it.move_steps;
					dir_q         = it.move_dir;
					if (flt_q) begin
						r.clear_driver_fault = 1'b1;
						flt_q                = 1'b0;
					end
					load_q      = LOAD_NORMAL;
					low_cnt     = '0;
					red_low_cnt = '0;
					speed_q     = cmd_speed;
					move_ticks  = '0;
					smp_div     = '0;
					mode_q      = MODE_RUN;
				end
			end
			CMD_STOP: begin
				r.timer_stop = 1'b1;
				mode_q       = MODE_IDLE;
				load_q       = LOAD_NORMAL;
				reason_q     = REASON_NORMAL;
			end
			CMD_CLEAR: begin
				r.clear_driver_fault = 1'b1;
				flt_q                = 1'b0;
				stl_q                = 1'b0;
				sw_err               = '0;
				if (mode_q == MODE_FAULT) begin
					mode_q = MODE_IDLE;
				end
			end
			default: supervise_tick(it, r);
		endcase
		r.mode          = mode_q;
		r.driver_enable = (mode_q == MODE_RUN);
		r.speed_now     = speed_q;
		r.load_state    = load_q;
		r.stop_reason   = reason_q;
		r.switch_errors = sw_err;
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		srs_out_t want;
		if (!arst_n) begin
			reset_model();
			expected_q.delete();
			failures = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				apply_register(cfg_index, cfg_data);
			end
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report_failure("result transaction with no command outstanding");
				end else begin
					want = expected_q.pop_front();
					check_field("mode", out_data.mode, want.mode);
					check_field("accepted", out_data.accepted, want.accepted);
					check_field("driver_enable", out_data.driver_enable, want.driver_enable);
					check_field("timer_start", out_data.timer_start, want.timer_start);
					check_field("timer_stop", out_data.timer_stop, want.timer_stop);
					check_field("step_target", out_data.step_target, want.step_target);
					check_field("speed_now", out_data.speed_now, want.speed_now);
					check_field("load_state", out_data.load_state, want.load_state);
					check_field("stop_reason", out_data.stop_reason, want.stop_reason);
					check_field("switch_errors", out_data.switch_errors, want.switch_errors);
					check_field("clear_driver_fault", out_data.clear_driver_fault,
						want.clear_driver_fault);
				end
			end
			if (in_valid && in_ready) begin
				supervise(in_data, want);
				expected_q.push_back(want);
			end
			pending <= expected_q.size();
		end
	end

endmodule

// File: verif/stepper_run_supervisor_unit_tb.sv
// ----------------------------------------------------------------------------
// stepper_run_supervisor_unit_tb
// Drives directed and random command streams into the stepper run supervisor
// under several register settings, with random gaps on the command side and
// random back-pressure on the result side, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module stepper_run_supervisor_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import srs_pkg::*;

	localparam int ITEM_TARGET = 1300;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	srs_in_t               in_data   = '0;
	logic                  out_ready = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic [2:0]            cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_ready;
	logic                  out_valid;
	srs_out_t              out_data;
	logic                  cfg_ready;
	int                    failures;
	int                    pending;

	logic [23:0]           reg_shadow [8];
	int                    sent = 0;

	stepper_run_supervisor_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	srs_checker u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.failures  (failures),
		.pending   (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		return (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 25);
	endfunction

	function automatic srs_in_t noise_item();
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		return raw[$bits(srs_in_t)-1:0];
	endfunction

	task automatic send_item(input srs_in_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	task automatic send_cmd(input cmd_t c);
		srs_in_t it;
		it     = noise_item();
		it.cmd = c;
		send_item(it);
	endtask

	task automatic send_move(input logic dir, input logic [23:0] steps);
		srs_in_t it;
		it            = noise_item();
		it.cmd        = CMD_MOVE;
		it.move_dir   = dir;
		it.move_steps = steps;
		send_item(it);
	endtask

	task automatic send_tick(input logic trun, input logic [23:0] sdone, input logic [2:0] flags,
			input logic [11:0] trq);
		srs_in_t it;
		it               = noise_item();
		it.cmd           = CMD_TICK;
		it.timer_running = trun;
		it.steps_done    = sdone;
		{it.driver_fault_bit, it.driver_stall_bit, it.fault_pin_low} = flags;
		it.torque_count  = trq;
		send_item(it);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [23:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		reg_shadow[idx] = d;
	endtask

	function automatic logic [12:0] rand_speed();
		if ($urandom_range(0, 9) == 0) begin
			return $urandom_range(0, 1) ? 13'h1FFF : 13'd0;
		end
		return 13'($urandom_range(1, 8000));
	endfunction

	function automatic logic [4:0] rand_count();
		return ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) :
			5'($urandom_range(1, 4));
	endfunction

	// Settings 0 and 1 put every register at its lowest and highest encoding;
	// the others favour short sample counts and run limits so that load
	// reduction, overload stops and timeouts happen within a move.
	task automatic program_setting(input int setting);
		logic [23:0] junk;
		logic [23:0] vals [8];
		junk = 24'($urandom);
		if (setting == 0) begin
			foreach (vals[i]) vals[i] = '0;
		end else if (setting == 1) begin
			foreach (vals[i]) vals[i] = 24'hFFFFFF;
		end else begin
			vals[REG_COMMAND_SPEED]    = {junk[23:13], rand_speed()};
			vals[REG_TORQUE_THRESHOLD] = {junk[23:12], ($urandom_range(0, 9) == 0) ?
				12'd0 : 12'($urandom_range(50, 4000))};
			vals[REG_REDUCED_SPEED]    = {junk[23:13], rand_speed()};
			vals[REG_LOW_TO_REDUCE]    = {junk[23:5], rand_count()};
			vals[REG_LOW_TO_STOP]      = {junk[23:5], rand_count()};
			vals[REG_UP_LEG_LIMIT]     = 24'($urandom_range(1, 24'hFFFFFF));
			vals[REG_DOWN_LEG_LIMIT]   = 24'($urandom_range(1, 24'hFFFFFF));
			vals[REG_RUN_LIMIT_TICKS]  = {junk[23:16], ($urandom_range(0, 99) < 60) ?
				16'($urandom_range(20, 150)) : 16'($urandom_range(151, 65535))};
		end
		for (int i = 0; i < 8; i++) begin
			write_reg(reg_idx_t'(i), vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// One move followed by ticks that mostly keep it running, with the odd
	// timer completion, leg overrun, driver fault, stop, clear or stray command.
	task automatic run_episode();
		logic        dir;
		logic [23:0] lim;
		logic [11:0] thr;
		logic [23:0] sdone;
		logic [11:0] trq;
		int          len;
		int          r;
		dir = 1'($urandom_range(0, 1));
		lim = dir ? reg_shadow[REG_DOWN_LEG_LIMIT] : reg_shadow[REG_UP_LEG_LIMIT];
		thr = (reg_shadow[REG_TORQUE_THRESHOLD][11:0] == 12'd0) ?
			12'd1 : reg_shadow[REG_TORQUE_THRESHOLD][11:0];
		r = $urandom_range(0, 99);
		send_move(dir, (r < 20) ? 24'd0 : (r < 30) ? 24'($urandom) : 24'($urandom_range(1, 5000)));
		len = ($urandom_range(0, 99) < 85) ? $urandom_range(8, 90) : $urandom_range(91, 260);
		for (int i = 0; i < len; i++) begin
			r     = $urandom_range(0, 999);
			trq   = ($urandom_range(0, 99) < 70) ? 12'($urandom_range(0, thr - 1)) :
				12'($urandom_range(thr, 4095));
			sdone = (lim == 24'd0) ? 24'($urandom) : 24'($urandom_range(0, lim - 1));
			if (r < 4) begin
				send_tick(1'b0, sdone, 3'b000, trq);
			end else if (r < 7) begin
				send_tick(1'b1, 24'($urandom_range(lim, 24'hFFFFFF)), 3'b000, trq);
			end else if (r < 11) begin
				send_tick(1'b1, sdone, 3'($urandom_range(1, 7)), trq);
			end else if (r < 14) begin
				send_cmd(CMD_STOP);
			end else if (r < 16) begin
				send_cmd(CMD_CLEAR);
			end else if (r < 30) begin
				send_item(noise_item());
			end else begin
				send_tick(1'b1, sdone, 3'b000, trq);
			end
		end
		r = $urandom_range(0, 9);
		if (r < 4) begin
			send_cmd(CMD_CLEAR);
		end else if (r < 6) begin
			send_cmd(CMD_STOP);
		end
	endtask

	initial begin : ready_gen
		int hold;
		int stall;
		int r;
		@(posedge clk);
		forever begin
			hold = ($urandom_range(0, 99) < 20) ? $urandom_range(40, 200) : $urandom_range(1, 8);
			out_ready <= 1'b1;
			repeat (hold) @(posedge clk);
			r     = $urandom_range(0, 99);
			stall = (r < 30) ? 0 : (r < 85) ? $urandom_range(1, 3) : $urandom_range(10, 30);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int setting;
		int budget;
		int first;
		reg_shadow[REG_COMMAND_SPEED]    = 24'(RST_COMMAND_SPEED);
		reg_shadow[REG_TORQUE_THRESHOLD] = 24'(RST_TORQUE_THRESH);
		reg_shadow[REG_REDUCED_SPEED]    = 24'(RST_REDUCED_SPEED);
		reg_shadow[REG_LOW_TO_REDUCE]    = 24'(RST_LOW_TO_REDUCE);
		reg_shadow[REG_LOW_TO_STOP]      = 24'(RST_LOW_TO_STOP);
		reg_shadow[REG_UP_LEG_LIMIT]     = RST_UP_LEG_LIMIT;
		reg_shadow[REG_DOWN_LEG_LIMIT]   = RST_DOWN_LEG_LIMIT;
		reg_shadow[REG_RUN_LIMIT_TICKS]  = 24'(RST_RUN_LIMIT);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed sequence under the reset register values.
		send_tick(1'b1, 24'hFFFFFF, 3'b111, 12'hFFF);
		send_move(1'b0, 24'd0);
		send_tick(1'b1, 24'd0, 3'b000, 12'd0);
		send_tick(1'b0, 24'd10, 3'b000, 12'd0);
		send_move(1'b1, 24'hFFFFFF);
		send_tick(1'b1, 24'hFFFFFF, 3'b000, 12'd500);
		send_move(1'b0, 24'd1234);
		send_tick(1'b1, RST_UP_LEG_LIMIT, 3'b000, 12'd500);
		send_cmd(CMD_CLEAR);
		send_move(1'b0, 24'd77);
		send_tick(1'b1, 24'd5, 3'b100, 12'd500);
		send_move(1'b1, 24'd88);
		send_tick(1'b1, 24'd5, 3'b000, 12'd500);
		send_cmd(CMD_STOP);
		send_move(1'b1, 24'd99);
		send_tick(1'b1, RST_DOWN_LEG_LIMIT - 24'd1, 3'b010, 12'd500);
		send_cmd(CMD_CLEAR);
		send_move(1'b0, 24'd0);
		send_tick(1'b1, 24'd5, 3'b001, 12'hFFF);
		send_cmd(CMD_CLEAR);
		send_cmd(CMD_STOP);
		send_move(1'b1, 24'd100);
		send_cmd(CMD_STOP);

		setting = 0;
		while (sent < ITEM_TARGET) begin
			wait_drained();
			program_setting(setting);
			budget = (setting < 2) ? 80 : 170;
			first  = sent;
			while ((sent - first < budget) && (sent < ITEM_TARGET)) begin
				if ($urandom_range(0, 99) < 85) begin
					run_episode();
				end else begin
					send_item(noise_item());
				end
			end
			setting++;
		end

		wait_drained();
		repeat (8) @(posedge clk);
		@(negedge clk);
		if (failures == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin : watchdog
		#1_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
